### rtl/two_segment_lru_buffer_cache_top_macros.svh
// Assertion macros for the two-segment LRU buffer cache.
// Used by two_segment_lru_buffer_cache_top only.
`ifndef TWO_SEGMENT_LRU_BUFFER_CACHE_TOP_MACROS_SVH
`define TWO_SEGMENT_LRU_BUFFER_CACHE_TOP_MACROS_SVH

// Implication checked on every edge outside reset.
`define TSLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define TSLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/tslc_pkg.sv
// Package for the two-segment LRU buffer cache: opcodes, result kinds,
// payload structs and engine state. No dependencies.
package tslc_pkg;

  localparam int unsigned SectorW = 24;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_DIRTY = 3'd2,
    OP_FILL  = 3'd3,
    OP_CLEAN = 3'd4,
    OP_FLUSH = 3'd5,
    OP_PROBE = 3'd6,
    OP_RSVD  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_WB     = 2'd1,
    KIND_RD     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ADDR_TOTAL = 2'd0,
    ADDR_HOT   = 2'd1
  } reg_addr_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_FLUSH,
    ST_EMIT
  } eng_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [SectorW-1:0] sector;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SectorW-1:0] req_sector;
    logic               read_first;
    logic               hit;
    logic               flushed;
    logic               fill_dropped;
    logic               last;
  } out_item_t;

endpackage

### rtl/two_segment_lru_buffer_cache_top.sv
// Two-segment LRU buffer cache: input queue -> engine -> result queue.
// A miss adds a read request before the status, an eviction of a dirty buffer adds a
// write-back before that, and a flush emits one write-back per dirty buffer before its
// status. The engine works on one item at a time and takes no new command until it is
// idle again.
// rst_ni (async, low) empties the store and queues; registers go to 16 / 4.
`include "two_segment_lru_buffer_cache_top_macros.svh"
module two_segment_lru_buffer_cache_top
  import tslc_pkg::*;
#(
  parameter int unsigned MAX_BUFFERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  in_item_t    in_item_i,
  output logic        full,
  input  logic        pop,
  output out_item_t   out_item_o,
  output logic        empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0] total_q;
  logic [3:0] hot_q;
  logic [4:0] tot_eff, hot_eff, cold_eff;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 5'd16;
      hot_q   <= 4'd4;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_addr_e'({1'b0, paddr[2]}))
        ADDR_TOTAL: total_q <= pwdata[4:0];
        ADDR_HOT:   hot_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_addr_e'({1'b0, paddr[2]}))
      ADDR_TOTAL: prdata = {27'd0, total_q};
      ADDR_HOT:   prdata = {28'd0, hot_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    tot_eff = total_q;
    if (tot_eff == '0) tot_eff = 5'd1;
    if (32'(tot_eff) > MAX_BUFFERS) tot_eff = 5'(MAX_BUFFERS);
    hot_eff = {1'b0, hot_q};
    if (hot_eff >= tot_eff) hot_eff = tot_eff - 1'b1;
    cold_eff = tot_eff - hot_eff;
  end

  logic           cq_empty, cq_pop;
  in_item_t       cq_data;
  tslc_fifo #(.Width($bits(in_item_t)), .Depth(2)) u_cmdq (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(cq_pop), .data_o(cq_data), .empty_o(cq_empty)
  );

  logic           r_push, r_full, busy;
  logic [1:0]     r_kind;
  logic [SectorW-1:0] r_sec;
  logic [4:0]     r_flags;
  out_item_t      r_item;

  tslc_engine #(.MaxBuffers(MAX_BUFFERS), .SectorBits(SectorW)) u_eng (
    .clk_i, .rst_ni,
    .cmd_valid_i(!cq_empty), .cmd_op_i(cq_data.operation),
    .cmd_sector_i(cq_data.sector), .cmd_pop_o(cq_pop),
    .hot_cap_i(hot_eff), .cold_cap_i(cold_eff),
    .res_push_o(r_push), .res_full_i(r_full),
    .res_kind_o(r_kind), .res_sector_o(r_sec), .res_flags_o(r_flags),
    .busy_o(busy)
  );

  assign r_item = '{kind: r_kind, req_sector: r_sec, read_first: r_flags[4],
                    hit: r_flags[3], flushed: r_flags[2],
                    fill_dropped: r_flags[1], last: r_flags[0]};

  tslc_fifo #(.Width($bits(out_item_t)), .Depth(2)) u_resq (
    .clk_i, .rst_ni, .push_i(r_push), .data_i(r_item), .full_o(r_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

  `TSLC_ASSERT_IMP(a_pop_ok, clk_i, rst_ni, cq_pop, !cq_empty)
  `TSLC_ASSERT_IMP(a_push_room, clk_i, rst_ni, r_push, !r_full)
  `TSLC_ASSERT_NXT(a_busy_after_pop, clk_i, rst_ni, cq_pop, busy)
endmodule

### rtl/tslc_fifo.sv
// Small synchronous FIFO with full/empty, used between front and back and on
// the result side. Depends on nothing.
module tslc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

### rtl/tslc_engine.sv
// Back end: tag store, ranks and the per-item sequencer of the cache.
// Depends on tslc_pkg.
module tslc_engine
  import tslc_pkg::*;
#(
  parameter int unsigned MaxBuffers = 16,
  parameter int unsigned SectorBits = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic [2:0]            cmd_op_i,
  input  logic [SectorBits-1:0] cmd_sector_i,
  output logic                  cmd_pop_o,
  input  logic [4:0]            hot_cap_i,
  input  logic [4:0]            cold_cap_i,
  output logic                  res_push_o,
  input  logic                  res_full_i,
  output logic [1:0]            res_kind_o,
  output logic [SectorBits-1:0] res_sector_o,
  output logic [4:0]            res_flags_o,
  output logic                  busy_o
);
  localparam int unsigned IW = $clog2(MaxBuffers);
  localparam int unsigned CW = IW + 1;

  logic [SectorBits-1:0] tag_q [MaxBuffers];
  logic [MaxBuffers-1:0] valid_q, dirty_q, hot_q;
  logic [CW-1:0]         rank_q [MaxBuffers];
  logic [CW-1:0]         cold_cnt_q, hot_cnt_q;

  eng_state_e state_q, state_d;
  logic [2:0]            op_q;
  logic [SectorBits-1:0] sec_q;
  logic                  hit_q, seg_q;
  logic [IW-1:0]         idx_q;
  logic [CW-1:0]         rk_q;

  // tag match, tail rank, flush rank, free slot: combinational scans, lowest index wins
  logic [MaxBuffers-1:0] match, tailm, flm;
  logic                  any_match, any_free, any_tail, any_fl;
  logic [IW-1:0]         match_idx, free_idx, tail_idx, fl_idx;
  logic                  evict_go, fill_go;

  always_comb begin
    match_idx = '0; free_idx = '0; tail_idx = '0; fl_idx = '0;
    any_match = 1'b0; any_free = 1'b0; any_tail = 1'b0; any_fl = 1'b0;
    for (int i = MaxBuffers - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (tag_q[i] == sec_q);
      tailm[i] = valid_q[i] && !hot_q[i] && (rank_q[i] == cold_cnt_q - 1'b1);
      flm[i]   = valid_q[i] && (hot_q[i] == seg_q) && (rank_q[i] == rk_q);
      if (match[i])    begin any_match = 1'b1; match_idx = IW'(i); end
      if (!valid_q[i]) begin any_free  = 1'b1; free_idx  = IW'(i); end
      if (tailm[i])    begin any_tail  = 1'b1; tail_idx  = IW'(i); end
      if (flm[i])      begin any_fl    = 1'b1; fl_idx    = IW'(i); end
    end
  end

  assign evict_go = (cold_cnt_q >= cold_cap_i) && (cold_cnt_q != '0) && any_tail;
  assign fill_go  = !any_match && any_free && (cold_cnt_q < cold_cap_i);

  // result staging
  logic                  emit_q, emit_last_q;
  logic [1:0]            ek_q;
  logic [SectorBits-1:0] es_q;
  logic [4:0]            ef_q; // read_first, hit, flushed, fill_dropped, last

  assign res_push_o   = emit_q && !res_full_i;
  assign res_kind_o   = ek_q;
  assign res_sector_o = es_q;
  assign res_flags_o  = ef_q;
  assign busy_o       = (state_q != ST_IDLE) || emit_q;
  assign cmd_pop_o    = (state_q == ST_IDLE) && !emit_q && cmd_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (cmd_pop_o) state_d = ST_LOOK;
      ST_LOOK: begin
        case (op_e'(op_q))
          OP_READ, OP_WRITE: state_d = (!any_match && evict_go) ? ST_EVICT : ST_EMIT;
          OP_FLUSH:          state_d = ST_FLUSH;
          default:           state_d = ST_EMIT;
        endcase
      end
      ST_EVICT: if (!emit_q && !dirty_q[idx_q]) state_d = ST_EMIT;
      ST_FLUSH: if (!emit_q && seg_q && rk_q == CW'(MaxBuffers - 1)) state_d = ST_EMIT;
      ST_EMIT:  if (emit_q && res_push_o && emit_last_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK && op_e'(op_q) == OP_FILL && fill_go) begin
      tag_q[free_idx] <= sec_q;
    end
  end

  // main sequential block: the sequencer drives store updates directly; tag writes sit in the block above
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      dirty_q    <= '0;
      hot_q      <= '0;
      cold_cnt_q <= '0;
      hot_cnt_q  <= '0;
      emit_q     <= 1'b0;
      emit_last_q <= 1'b0;
      op_q       <= '0;
      sec_q      <= '0;
      hit_q      <= 1'b0;
      seg_q      <= 1'b0;
      idx_q      <= '0;
      rk_q       <= '0;
      ek_q       <= '0;
      es_q       <= '0;
      ef_q       <= '0;
      for (int i = 0; i < MaxBuffers; i++) rank_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (res_push_o) emit_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            op_q  <= cmd_op_i;
            sec_q <= cmd_sector_i;
          end
        end
        ST_LOOK: begin
          hit_q <= any_match;
          idx_q <= tail_idx;
          case (op_e'(op_q))
            OP_READ, OP_WRITE: begin
              if (any_match) begin
                if (!hot_q[match_idx]) begin
                  for (int j = 0; j < MaxBuffers; j++) begin
                    if (j != int'(match_idx) && valid_q[j]) begin
                      if (hot_cnt_q < hot_cap_i) begin
                        if (!hot_q[j] && rank_q[j] > rank_q[match_idx])
                          rank_q[j] <= rank_q[j] - 1'b1;
                        else if (hot_q[j]) rank_q[j] <= rank_q[j] + 1'b1;
                      end else if (!hot_q[j] && rank_q[j] < rank_q[match_idx]) begin
                        rank_q[j] <= rank_q[j] + 1'b1;
                      end
                    end
                  end
                  rank_q[match_idx] <= '0;
                  if (hot_cnt_q < hot_cap_i) begin
                    hot_q[match_idx] <= 1'b1;
                    hot_cnt_q  <= hot_cnt_q + 1'b1;
                    cold_cnt_q <= cold_cnt_q - 1'b1;
                  end
                end
              end else if (!evict_go) begin
                ek_q <= KIND_RD; es_q <= sec_q;
                ef_q <= {op_q == OP_WRITE, 4'b0};
                emit_q <= 1'b1;
              end
            end
            OP_DIRTY, OP_CLEAN: begin
              if (any_match) dirty_q[match_idx] <= (op_q == OP_DIRTY);
            end
            OP_FILL: begin
              if (fill_go) begin
                for (int j = 0; j < MaxBuffers; j++)
                  if (valid_q[j] && !hot_q[j]) rank_q[j] <= rank_q[j] + 1'b1;
                valid_q[free_idx] <= 1'b1;
                dirty_q[free_idx] <= 1'b0;
                hot_q[free_idx]   <= 1'b0;
                rank_q[free_idx]  <= '0;
                cold_cnt_q <= cold_cnt_q + 1'b1;
                rk_q  <= '0;
              end else begin
                rk_q <= {CW{!any_match}};
              end
            end
            OP_FLUSH: begin
              hit_q <= (cold_cnt_q != '0) || (hot_cnt_q != '0);
              seg_q <= 1'b0;
              rk_q  <= '0;
            end
            default: ;
          endcase
        end
        ST_EVICT: begin
          if (!emit_q || res_push_o) begin
            if (dirty_q[idx_q] && !emit_q) begin
              ek_q <= KIND_WB; es_q <= tag_q[idx_q]; ef_q <= '0;
              emit_q <= 1'b1;
              dirty_q[idx_q] <= 1'b0;
            end else if (!emit_q) begin
              valid_q[idx_q] <= 1'b0;
              hot_q[idx_q]   <= 1'b0;
              rank_q[idx_q]  <= '0;
              cold_cnt_q     <= cold_cnt_q - 1'b1;
              ek_q <= KIND_RD; es_q <= sec_q;
              ef_q <= {op_q == OP_WRITE, 4'b0};
              emit_q <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!emit_q) begin
            if (any_fl && dirty_q[fl_idx]) begin
              ek_q <= KIND_WB; es_q <= tag_q[fl_idx]; ef_q <= '0;
              emit_q <= 1'b1;
            end
            if (rk_q == CW'(MaxBuffers - 1)) begin
              rk_q <= '0;
              if (seg_q) begin
                valid_q <= '0; dirty_q <= '0; hot_q <= '0;
                for (int i = 0; i < MaxBuffers; i++) rank_q[i] <= '0;
                cold_cnt_q <= '0; hot_cnt_q <= '0;
              end
              seg_q <= 1'b1;
            end else begin
              rk_q <= rk_q + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (!emit_q) begin
            ek_q <= KIND_STATUS; es_q <= sec_q;
            case (op_e'(op_q))
              OP_FLUSH: ef_q <= {2'b00, hit_q, 2'b01};
              OP_FILL:  ef_q <= {1'b0, (rk_q != '0) ? 1'b0 : hit_q, 1'b0, rk_q[0], 1'b1};
              OP_RSVD:  ef_q <= 5'b00001;
              default:  ef_q <= {1'b0, hit_q, 3'b001};
            endcase
            emit_q <= 1'b1;
            emit_last_q <= 1'b1;
          end else if (res_push_o && emit_last_q) begin
            emit_last_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
